// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that cond is never true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: rtl/core/psfp_pkg.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser package
// Frame geometry, register reset value and controller state type.
// ----------------------------------------------------------------------------
package psfp_pkg;

    // Bytes in one frame, start byte and checksum pair included (8 to 64).
    localparam int FRAME_BYTES = 32;
    // Measurement words emitted per frame.
    localparam int MEAS_WORDS  = 12;

    localparam int ADDR_W = $clog2(FRAME_BYTES);
    // Wide enough for any word byte position and for FRAME_BYTES itself.
    localparam int POS_W  = 7;
    localparam int WIDX_W = 4;

    localparam logic [7:0] START_BYTE_RESET = 8'h42;

    // First byte of the frame length word and of the first measurement word.
    localparam int FLEN_POS  = 2;
    localparam int WORD0_POS = 4;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_COLLECT,
        ST_READ_HI,
        ST_READ_LO,
        ST_SHOW
    } state_t;

endpackage

// File: rtl/core/particle_sensor_frame_parser_core.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser core
// Hunts for the start byte, stores a frame, checks its sum, emits twelve words.
// ----------------------------------------------------------------------------
// Takes one serial byte per cycle while hunting or collecting a frame. Bytes
// other than start_byte are dropped while hunting; the matching byte opens a
// frame of FRAME_BYTES bytes that is written into the frame store, while the
// byte sum, the length word and the checksum high byte are kept in registers.
// After the last byte the block reads the twelve measurement words back
// through the store's single read port, two reads per word (READ_HI, then
// READ_LO), and holds each result in SHOW until out_ready is high; in_ready
// is low for that whole readout.
`include "assert_macros.svh"

module particle_sensor_frame_parser_core
    import psfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [WIDX_W-1:0]   word_index,
    output logic [15:0]         word_value,
    output logic [15:0]         frame_length,
    output logic                checksum_ok,
    output logic                is_last
);

    localparam logic [ADDR_W-1:0] POS_LAST     = ADDR_W'(FRAME_BYTES - 1);
    localparam logic [ADDR_W-1:0] POS_CHK_HI   = ADDR_W'(FRAME_BYTES - 2);
    localparam logic [ADDR_W-1:0] POS_FLEN_HI  = ADDR_W'(FLEN_POS);
    localparam logic [ADDR_W-1:0] POS_FLEN_LO  = ADDR_W'(FLEN_POS + 1);
    localparam logic [POS_W-1:0]  DATA_END     = POS_W'(FRAME_BYTES - 2);
    localparam logic [WIDX_W-1:0] WIDX_LAST    = WIDX_W'(MEAS_WORDS - 1);

    state_t              state_reg, state_next;
    logic [7:0]          start_byte_reg;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [15:0]         sum_reg, sum_next;
    logic [WIDX_W-1:0]   widx_reg, widx_next;

    logic [7:0]          flen_hi_reg, flen_lo_reg;
    logic [7:0]          chk_hi_reg;
    logic                ok_reg;
    logic [7:0]          hi_byte_reg;

    logic [7:0]          frame_store [FRAME_BYTES];
    logic [7:0]          rd_data_reg;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;

    logic                in_fire, out_fire, start_hit;
    logic [POS_W-1:0]    hi_pos, lo_pos;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign start_hit = (rx_byte == start_byte_reg);

    assign hi_pos = POS_W'({widx_reg, 1'b0}) + POS_W'(WORD0_POS);
    assign lo_pos = hi_pos + POS_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT:
                if (in_fire && start_hit)
                    state_next = ST_COLLECT;
            ST_COLLECT:
                if (in_fire && pos_reg == POS_LAST)
                    state_next = ST_READ_HI;
            ST_READ_HI:
                state_next = ST_READ_LO;
            ST_READ_LO:
                state_next = ST_SHOW;
            ST_SHOW:
                if (out_ready)
                    state_next = (widx_reg == WIDX_LAST) ? ST_HUNT : ST_READ_HI;
            default:
                state_next = ST_HUNT;
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = hi_pos[ADDR_W-1:0];
        unique case (state_reg)
            ST_HUNT, ST_COLLECT:
                in_ready = 1'b1;
            ST_READ_HI:
                rd_en = 1'b1;
            ST_READ_LO:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_pos[ADDR_W-1:0];
            end
            ST_SHOW:
                out_valid = 1'b1;
            default:
                in_ready = 1'b0;
        endcase
    end

    // Byte position, running sum and word index
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        widx_next = widx_reg;
        wr_en     = 1'b0;
        if (in_fire)
        begin
            if (state_reg == ST_HUNT)
            begin
                if (start_hit)
                begin
                    wr_en    = 1'b1;
                    pos_next = ADDR_W'(1);
                    sum_next = {8'h00, rx_byte};
                end
            end
            else
            begin
                wr_en = 1'b1;
                if (pos_reg == POS_LAST)
                begin
                    pos_next = '0;
                    sum_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + ADDR_W'(1);
                    // The checksum pair stays out of the sum.
                    if (pos_reg < POS_CHK_HI)
                        sum_next = sum_reg + {8'h00, rx_byte};
                end
            end
        end
        if (out_fire)
            widx_next = (widx_reg == WIDX_LAST) ? '0 : widx_reg + WIDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_HUNT;
            start_byte_reg <= START_BYTE_RESET;
            pos_reg        <= '0;
            sum_reg        <= '0;
            widx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            widx_reg  <= widx_next;
            if (cfg_wr_en)
                start_byte_reg <= cfg_wr_data;
        end
    end

    // Frame header, checksum and readout holding registers
    always_ff @(posedge clk)
    begin
        if (in_fire && state_reg == ST_COLLECT)
        begin
            if (pos_reg == POS_FLEN_HI)
                flen_hi_reg <= rx_byte;
            if (pos_reg == POS_FLEN_LO)
                flen_lo_reg <= rx_byte;
            if (pos_reg == POS_CHK_HI)
                chk_hi_reg <= rx_byte;
            if (pos_reg == POS_LAST)
                ok_reg <= (sum_reg == {chk_hi_reg, rx_byte});
        end
        // High byte read returns while the low byte read is issued.
        if (state_reg == ST_READ_LO)
            hi_byte_reg <= rd_data_reg;
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_store[pos_reg] <= rx_byte;
        if (rd_en)
            rd_data_reg <= frame_store[rd_addr];
    end

    // Bytes at or past the checksum pair read as zero.
    assign word_value   = {(hi_pos < DATA_END) ? hi_byte_reg : 8'h00,
                           (lo_pos < DATA_END) ? rd_data_reg : 8'h00};
    assign word_index   = widx_reg;
    assign frame_length = {flen_hi_reg, flen_lo_reg};
    assign checksum_ok  = ok_reg;
    assign is_last      = (widx_reg == WIDX_LAST);

    `ASSERT_NEVER(a_no_in_during_out, clk, rst_n, in_ready && out_valid, "input open during readout")
    `ASSERT_PROP(a_last_byte_starts_read, clk, rst_n, (in_fire && state_reg == ST_COLLECT && pos_reg == POS_LAST) |=> (state_reg == ST_READ_HI && widx_reg == '0 && pos_reg == '0), "final byte did not start readout")
    `ASSERT_PROP(a_word_advance, clk, rst_n, (out_fire && !is_last) |=> (widx_reg == $past(widx_reg) + WIDX_W'(1) && state_reg == ST_READ_HI), "word index did not advance")
    `ASSERT_PROP(a_last_beat_hunts, clk, rst_n, (out_fire && is_last) |=> (state_reg == ST_HUNT && pos_reg == '0 && sum_reg == '0), "last beat did not return to hunting")

endmodule

// File: bench/tb_particle_sensor_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle sensor frame parser core testbench
// Sends serial bytes as frames, noise and broken frames under random gaps and
// stalls, predicts the twelve words of every completed frame and checks each
// word as it leaves the block.
// ----------------------------------------------------------------------------
module tb_particle_sensor_frame_parser_core;
    import psfp_pkg::*;

    localparam int STORE_DEPTH   = 64;
    localparam int RANDOM_ITEMS  = 96;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 4000;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS,
        FILL_START_MIX
    } fill_t;

    typedef struct packed {
        logic [WIDX_W-1:0] idx;
        logic [15:0]       value;
        logic [15:0]       flen;
        logic              ok;
        logic              last;
    } word_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [7:0]        cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_ready;
    logic [WIDX_W-1:0] word_index;
    logic [15:0]       word_value;
    logic [15:0]       frame_length;
    logic              checksum_ok;
    logic              is_last;

    // Frame parser mirror
    logic [7:0]        start_code;
    bit                frame_open;
    int                fill_pos;
    logic [15:0]       byte_sum;
    logic [7:0]        frame_mem [STORE_DEPTH];
    word_t             word_q [$];

    bit                no_gaps;
    bit                no_stalls;
    int                error_count;
    int                data_bytes;
    int                frames_done;
    int                words_checked;
    int                bad_sums;
    int                start_writes;

    particle_sensor_frame_parser_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word_index   (word_index),
        .word_value   (word_value),
        .frame_length (frame_length),
        .checksum_ok  (checksum_ok),
        .is_last      (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int frame_size();
        int n;
        n = FRAME_BYTES;
        if (n < 8)
            n = 8;
        if (n > STORE_DEPTH)
            n = STORE_DEPTH;
        return n;
    endfunction

    // Bytes at or past the checksum pair read as zero.
    function automatic logic [7:0] data_at(int pos, int n);
        if (pos >= n - 2)
            return 8'h00;
        return frame_mem[pos % STORE_DEPTH];
    endfunction

    // Advance the mirror by one accepted byte; returns 0 if the byte was dropped.
    function automatic bit parse_byte(logic [7:0] b);
        int          n;
        logic [15:0] chk;
        logic [15:0] flen;
        word_t       w;
        n = frame_size();
        if (!frame_open)
        begin
            if (b != start_code)
                return 1'b0;
            frame_open   = 1'b1;
            frame_mem[0] = b;
            byte_sum     = {8'h00, b};
            fill_pos     = 1;
            return 1'b1;
        end
        frame_mem[fill_pos % STORE_DEPTH] = b;
        if (fill_pos < n - 2)
            byte_sum = byte_sum + {8'h00, b};
        if (fill_pos + 1 < n)
        begin
            fill_pos++;
            return 1'b1;
        end
        chk  = {frame_mem[(n - 2) % STORE_DEPTH], frame_mem[(n - 1) % STORE_DEPTH]};
        flen = {data_at(FLEN_POS, n), data_at(FLEN_POS + 1, n)};
        for (int k = 0; k < MEAS_WORDS; k++)
        begin
            w.idx   = k[WIDX_W-1:0];
            w.value = {data_at(WORD0_POS + 2 * k, n), data_at(WORD0_POS + 2 * k + 1, n)};
            w.flen  = flen;
            w.ok    = (byte_sum == chk);
            w.last  = (k == MEAS_WORDS - 1);
            word_q.push_back(w);
        end
        if (byte_sum != chk)
            bad_sums++;
        frames_done++;
        frame_open = 1'b0;
        fill_pos   = 0;
        byte_sum   = 16'h0000;
        return 1'b1;
    endfunction

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 19));
    endfunction

    // Present one byte after a random gap and hold it until accepted.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = draw_wait(no_gaps);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (parse_byte(b))
            data_bytes++;
    endtask

    task automatic send_frame(fill_t fill, bit good_sum);
        logic [7:0]  fb [STORE_DEPTH];
        logic [15:0] s;
        int          n;
        n     = frame_size();
        fb[0] = start_code;
        s     = {8'h00, start_code};
        for (int i = 1; i < n - 2; i++)
        begin
            case (fill)
                FILL_ONES:      fb[i] = 8'hFF;
                FILL_ZEROS:     fb[i] = 8'h00;
                FILL_START_MIX: fb[i] = ($urandom_range(0, 2) == 0) ? start_code
                                                                    : 8'($urandom);
                default:        fb[i] = 8'($urandom);
            endcase
            s = s + {8'h00, fb[i]};
        end
        if (!good_sum)
            s = s ^ 16'($urandom_range(1, 65535));
        fb[n - 2] = s[15:8];
        fb[n - 1] = s[7:0];
        for (int i = 0; i < n; i++)
            send_byte(fb[i]);
    endtask

    // Finish any open frame, drop valid and wait for every word to drain.
    task automatic quiesce();
        while (frame_open)
            send_byte(8'($urandom));
        @(negedge clk);
        in_valid <= 1'b0;
        while (word_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_start(logic [7:0] v);
        quiesce();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        start_code = v;
        start_writes++;
    endtask

    task automatic test_directed_frames();
        no_gaps   = 1'b0;
        no_stalls = 1'b0;
        // None of these match the reset start byte: all dropped.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(8'h43);
        send_frame(FILL_ONES, 1'b1);
        send_frame(FILL_ZEROS, 1'b0);
        send_frame(FILL_START_MIX, 1'b1);
        no_gaps   = 1'b1;
        no_stalls = 1'b1;
        send_frame(FILL_RANDOM, 1'b1);
    endtask

    task automatic test_start_settings();
        no_gaps   = 1'b0;
        no_stalls = 1'b0;
        write_start(8'h00);
        send_byte(8'h01);
        send_frame(FILL_ZEROS, 1'b1);
        write_start(8'hFF);
        send_byte(8'hFE);
        send_frame(FILL_ONES, 1'b1);
        write_start(8'($urandom));
        send_byte(start_code ^ 8'h80);
        send_frame(FILL_RANDOM, 1'b0);
        write_start(START_BYTE_RESET);
        send_frame(FILL_START_MIX, 1'b1);
    endtask

    task automatic test_random_traffic();
        int         base;
        int         choice;
        int         cfg_changes;
        logic [7:0] b;
        base        = data_bytes;
        cfg_changes = 0;
        while (data_bytes - base < RANDOM_ITEMS)
        begin
            choice    = $urandom_range(0, 99);
            no_gaps   = ($urandom_range(0, 3) == 0);
            no_stalls = ($urandom_range(0, 3) == 0);
            if (choice < 8)
            begin
                // Line noise between frames
                repeat ($urandom_range(1, 4))
                begin
                    b = 8'($urandom);
                    if ($urandom_range(0, 9) != 0)
                        while (b == start_code)
                            b = 8'($urandom);
                    send_byte(b);
                end
            end
            else if (choice < 16)
            begin
                // Cut-off frame: the next frame's bytes land inside it
                send_byte(start_code);
                repeat ($urandom_range(1, 20))
                    send_byte(8'($urandom));
            end
            else if (choice < 20 && cfg_changes < 4)
            begin
                write_start(8'($urandom));
                cfg_changes++;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       send_frame(FILL_ONES, $urandom_range(0, 3) != 0);
                    1:       send_frame(FILL_ZEROS, $urandom_range(0, 3) != 0);
                    2, 3:    send_frame(FILL_START_MIX, $urandom_range(0, 3) != 0);
                    default: send_frame(FILL_RANDOM, $urandom_range(0, 3) != 0);
                endcase
            end
        end
    endtask

    // Result side: random stall before each beat, then compare with the oldest word.
    initial
    begin
        int    stall;
        word_t exp_w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = draw_wait(no_stalls);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (word_q.size() == 0)
            begin
                $error("unexpected word: index %0d value %04h", word_index, word_value);
                error_count++;
            end
            else
            begin
                exp_w = word_q.pop_front();
                words_checked++;
                if (word_index !== exp_w.idx)
                begin
                    $error("word_index: expected %0d, got %0d", exp_w.idx, word_index);
                    error_count++;
                end
                if (word_value !== exp_w.value)
                begin
                    $error("word_value: expected %04h, got %04h", exp_w.value, word_value);
                    error_count++;
                end
                if (frame_length !== exp_w.flen)
                begin
                    $error("frame_length: expected %04h, got %04h", exp_w.flen, frame_length);
                    error_count++;
                end
                if (checksum_ok !== exp_w.ok)
                begin
                    $error("checksum_ok: expected %0b, got %0b", exp_w.ok, checksum_ok);
                    error_count++;
                end
                if (is_last !== exp_w.last)
                begin
                    $error("is_last: expected %0b, got %0b", exp_w.last, is_last);
                    error_count++;
                end
            end
        end
    end

    // End the run if no beat moves on either side for too long.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no beat for %0d cycles, %0d words pending", IDLE_LIMIT,
                 word_q.size());
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 8'h00;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        start_code    = START_BYTE_RESET;
        frame_open    = 1'b0;
        fill_pos      = 0;
        byte_sum      = 16'h0000;
        no_gaps       = 1'b0;
        no_stalls     = 1'b0;
        error_count   = 0;
        data_bytes    = 0;
        frames_done   = 0;
        words_checked = 0;
        bad_sums      = 0;
        start_writes  = 0;
        foreach (frame_mem[i])
            frame_mem[i] = 8'h00;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_start_settings();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        while (word_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("frames: %0d (%0d with bad checksum), words checked: %0d", frames_done,
                 bad_sums, words_checked);
        $display("frame bytes accepted: %0d, start byte writes: %0d", data_bytes,
                 start_writes);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
